@@ rtl/core/lcde_pkg.sv @@
// Shared types and constants of the LUT cut depth engine.
package lcde_pkg;

  localparam int unsigned ID_W    = 12;
  localparam int unsigned LEAF_W  = 12;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned DEPTH_W = 32;
  localparam int unsigned PER_W   = 12;
  localparam int unsigned OP_W    = 3;

  // opcodes
  localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_AND   = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd2;
  localparam logic [OP_W-1:0] OP_COPY  = 3'd3;
  localparam logic [OP_W-1:0] OP_SET   = 3'd4;

  // register indexes
  localparam logic CFG_LUT_SIZE = 1'b0;
  localparam logic CFG_PERIOD   = 1'b1;

  localparam logic [CNT_W-1:0] LUT_SIZE_RST = 4'd6;

  // one node entry: cut leaf count and depth
  typedef struct packed {
    logic [CNT_W-1:0]   cnt;
    logic [DEPTH_W-1:0] depth;
  } node_ent_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NRD,
    ST_PREP,
    ST_LOAD,
    ST_MERGE,
    ST_RESOLVE,
    ST_WLEAF,
    ST_WNODE,
    ST_DONE
  } lcde_state_e;

endpackage

@@ rtl/core/lut_cut_depth_engine.sv @@
// An and-node loads, merges and writes back its leaves one leaf RAM entry per cycle.
// One word is processed at a time; the next word is taken the cycle after the result is
// registered, and an output stall delays that registration.
// Reset: asynchronous, active low; then a clearing pass sweeps the node RAM to zero while
// input is stalled; configuration writes are taken throughout.
module lut_cut_depth_engine #(
  parameter int unsigned MAX_NODES  = 4096,
  parameter int unsigned MAX_LEAVES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lcde_pkg::OP_W-1:0]           opcode_i,
  input  logic [lcde_pkg::ID_W-1:0]           node_id_i,
  input  logic [lcde_pkg::ID_W-1:0]           fanin_a_i,
  input  logic [lcde_pkg::ID_W-1:0]           fanin_b_i,
  input  logic [lcde_pkg::ID_W-1:0]           sibling_id_i,
  input  logic [lcde_pkg::ID_W-1:0]           source_id_i,
  input  logic                                subtract_period_i,
  input  logic signed [lcde_pkg::DEPTH_W-1:0] depth_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lcde_pkg::DEPTH_W-1:0] node_depth_o,
  output logic [lcde_pkg::CNT_W-1:0]          cut_size_o,
  output logic                                depth_changed_o,
  output logic                                over_period_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [lcde_pkg::PER_W-1:0]          cfg_data_i
);

  import lcde_pkg::*;

  localparam int unsigned NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned LAW = $clog2(MAX_NODES * MAX_LEAVES);
  localparam int unsigned SW  = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
  localparam int unsigned LW  = CNT_W + 1;

  // node id to memory row (ids are narrow, so at most eight compare-subtract steps)
  function automatic logic [NW-1:0] node_of(input logic [ID_W-1:0] id);
    logic [31:0] v;
    v = {{(32-ID_W){1'b0}}, id};
    if (MAX_NODES < (1 << ID_W)) begin
      for (int s = 7; s >= 0; s--) begin
        if (v >= (32'(MAX_NODES) << s)) begin
          v = v - (32'(MAX_NODES) << s);
        end
      end
    end
    return v[NW-1:0];
  endfunction

  function automatic logic [LAW-1:0] leaf_addr(input logic [NW-1:0] node,
                                               input logic [CNT_W-1:0] slot);
    return LAW'(LAW'(node) * LAW'(MAX_LEAVES) + LAW'(slot));
  endfunction

  // configuration
  logic [CNT_W-1:0] lut_size_q;
  logic [PER_W-1:0] period_q;
  logic [CNT_W-1:0] k_lim;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lut_size_q <= LUT_SIZE_RST;
      period_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LUT_SIZE: lut_size_q <= cfg_data_i[CNT_W-1:0];
        CFG_PERIOD:   period_q   <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_comb begin
    priority if (lut_size_q < CNT_W'(2))               k_lim = CNT_W'(2);
    else if (lut_size_q > CNT_W'(MAX_LEAVES))          k_lim = CNT_W'(MAX_LEAVES);
    else                                               k_lim = lut_size_q;
  end

  // state and item registers
  lcde_state_e state_q, state_d;
  logic [OP_W-1:0]    op_q;
  logic [ID_W-1:0]    id_q, fa_q, fb_q;
  logic [NW-1:0]      n_q, n0_q, n1_q, ns_q, nsrc_q;
  logic               sib_nz_q, subp_q;
  logic [DEPTH_W-1:0] dv_q;
  logic [2:0]         step_q;
  node_ent_t          rd_q [4];
  logic [NW-1:0]      clr_q;

  // and-node working registers
  logic [NW-1:0]      a_node_q, b_node_q;
  logic [CNT_W-1:0]   ka_q, kb_q;
  logic               bcut_q;
  logic [DEPTH_W-1:0] lvl_q;
  logic [LW-1:0]      ld_q;
  logic [LEAF_W-1:0]  abuf_q [MAX_LEAVES];
  logic [LEAF_W-1:0]  bbuf_q [MAX_LEAVES];
  logic [LEAF_W-1:0]  rbuf_q [MAX_LEAVES];
  logic [CNT_W-1:0]   i_q, j_q, m_q;
  logic               ovf_q;
  logic [CNT_W-1:0]   fin_cnt_q;
  logic [DEPTH_W-1:0] fin_lvl_q;
  logic               use_sib_q;
  logic [LW-1:0]      wl_q;

  // output buffer
  logic               out_valid_q;
  logic [DEPTH_W-1:0] out_depth_q;
  logic [CNT_W-1:0]   out_cnt_q;
  logic               out_chg_q, out_over_q;

  // memories
  logic              nd_we;
  logic [NW-1:0]     nd_waddr, nd_raddr;
  node_ent_t         nd_wdata, nd_rdata;
  logic              lf_we;
  logic [LAW-1:0]    lf_waddr, lf_raddr;
  logic [LEAF_W-1:0] lf_wdata, lf_rdata;

  lcde_ram #(.DEPTH(MAX_NODES), .WIDTH(CNT_W + DEPTH_W), .AW(NW)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (nd_we),
    .waddr_i (nd_waddr),
    .wdata_i (nd_wdata),
    .raddr_i (nd_raddr),
    .rdata_o (nd_rdata)
  );

  lcde_ram #(.DEPTH(MAX_NODES * MAX_LEAVES), .WIDTH(LEAF_W), .AW(LAW)) u_leaf_ram (
    .clk_i   (clk_i),
    .we_i    (lf_we),
    .waddr_i (lf_waddr),
    .wdata_i (lf_wdata),
    .raddr_i (lf_raddr),
    .rdata_o (lf_rdata)
  );

  logic in_fire, out_free;
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // node reads per opcode
  logic [2:0] nreads;
  always_comb begin
    priority if (op_q == OP_AND) nreads = 3'd4;
    else if (op_q == OP_COPY)    nreads = 3'd2;
    else                         nreads = 3'd1;
  end

  logic [LW-1:0] ld_total;
  assign ld_total = LW'(ka_q) + (bcut_q ? LW'(kb_q) : LW'(0));

  // merge step
  logic              m_more, m_take_a, m_take_b;
  logic [LEAF_W-1:0] m_val, m_av, m_bv;
  always_comb begin
    m_av     = abuf_q[i_q[SW-1:0]];
    m_bv     = bbuf_q[j_q[SW-1:0]];
    m_more   = (i_q < ka_q) || (j_q < kb_q);
    m_take_a = 1'b0;
    m_take_b = 1'b0;
    m_val    = m_bv;
    if ((i_q < ka_q) && (j_q < kb_q)) begin
      if (m_av == m_bv) begin
        m_take_a = 1'b1; m_take_b = 1'b1; m_val = m_av;
      end else if (m_av < m_bv) begin
        m_take_a = 1'b1; m_val = m_av;
      end else begin
        m_take_b = 1'b1;
      end
    end else if (i_q < ka_q) begin
      m_take_a = 1'b1; m_val = m_av;
    end else begin
      m_take_b = 1'b1;
    end
  end

  // overflow fallback and sibling choice
  logic [LEAF_W-1:0]  f_lo, f_hi;
  logic [CNT_W-1:0]   c_cnt;
  logic [DEPTH_W-1:0] c_lvl;
  logic               c_sib;
  always_comb begin
    f_lo  = (fa_q < fb_q) ? fa_q : fb_q;
    f_hi  = (fa_q < fb_q) ? fb_q : fa_q;
    c_cnt = ovf_q ? ((f_lo == f_hi) ? CNT_W'(1) : CNT_W'(2)) : m_q;
    c_lvl = lvl_q;
    if (ovf_q && (lvl_q != {1'b0, {(DEPTH_W-1){1'b1}}})) begin
      c_lvl = lvl_q + DEPTH_W'(1);
    end
    c_sib = sib_nz_q &&
            !(($signed(c_lvl) < $signed(rd_q[2].depth)) ||
              ((c_lvl == rd_q[2].depth) && (c_cnt <= rd_q[2].cnt)));
  end

  // result of the item
  logic [DEPTH_W:0]   sub_d;
  logic [DEPTH_W-1:0] r_depth;
  logic [CNT_W-1:0]   r_cnt;
  logic               r_chg, r_over, r_write;
  always_comb begin
    sub_d   = {rd_q[0].depth[DEPTH_W-1], rd_q[0].depth} -
              (subp_q ? {{(DEPTH_W+1-PER_W){1'b0}}, period_q} : '0);
    r_depth = rd_q[0].depth;
    r_cnt   = rd_q[0].cnt;
    r_chg   = 1'b0;
    r_over  = 1'b0;
    r_write = 1'b0;
    unique case (op_q)
      OP_INIT: begin
        r_depth = '0; r_cnt = CNT_W'(1); r_write = 1'b1;
      end
      OP_AND: begin
        r_chg   = $signed(fin_lvl_q) > $signed(rd_q[3].depth);
        r_depth = r_chg ? fin_lvl_q : rd_q[3].depth;
        r_cnt   = fin_cnt_q;
        r_write = 1'b1;
      end
      OP_QUERY: begin
        r_over = $signed(rd_q[0].depth) > $signed({{(DEPTH_W-PER_W){1'b0}}, period_q});
      end
      OP_COPY: begin
        r_depth = (sub_d[DEPTH_W] != sub_d[DEPTH_W-1]) ? {1'b1, {(DEPTH_W-1){1'b0}}}
                                                      : sub_d[DEPTH_W-1:0];
        r_cnt   = rd_q[1].cnt;
        r_write = 1'b1;
      end
      OP_SET: begin
        r_depth = dv_q; r_write = 1'b1;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (clr_q == NW'(MAX_NODES - 1)) state_d = ST_IDLE;
      ST_IDLE:    if (in_fire) state_d = (opcode_i == OP_INIT) ? ST_WNODE : ST_NRD;
      ST_NRD:     if (step_q == nreads) state_d = (op_q == OP_AND) ? ST_PREP : ST_WNODE;
      ST_PREP:    state_d = ST_LOAD;
      ST_LOAD:    if (ld_q == ld_total) state_d = ST_MERGE;
      ST_MERGE:   if (!m_more || (m_q >= k_lim)) state_d = ST_RESOLVE;
      ST_RESOLVE: state_d = ST_WLEAF;
      ST_WLEAF:   if (wl_q == LW'(fin_cnt_q)) state_d = ST_WNODE;
      ST_WNODE:   state_d = ST_DONE;
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    nd_we      = 1'b0;
    nd_waddr   = n_q;
    nd_wdata   = '{cnt: r_cnt, depth: r_depth};
    nd_raddr   = n_q;
    lf_we      = 1'b0;
    lf_waddr   = leaf_addr(n_q, CNT_W'(wl_q));
    lf_wdata   = rbuf_q[wl_q[SW-1:0]];
    lf_raddr   = leaf_addr(ns_q, CNT_W'(wl_q));
    if (op_q == OP_AND) begin
      unique case (step_q)
        3'd0:    nd_raddr = n0_q;
        3'd1:    nd_raddr = n1_q;
        3'd2:    nd_raddr = ns_q;
        default: nd_raddr = n_q;
      endcase
    end else if (op_q == OP_COPY && step_q == 3'd0) begin
      nd_raddr = nsrc_q;
    end
    unique case (state_q)
      ST_CLEAR: begin
        nd_we    = 1'b1;
        nd_waddr = clr_q;
        nd_wdata = '0;
      end
      ST_LOAD: begin
        lf_raddr = (ld_q < LW'(ka_q)) ? leaf_addr(a_node_q, CNT_W'(ld_q))
                                      : leaf_addr(b_node_q, CNT_W'(ld_q - LW'(ka_q)));
      end
      ST_WLEAF: begin
        if (use_sib_q) begin
          lf_we    = (wl_q != '0);
          lf_waddr = leaf_addr(n_q, CNT_W'(wl_q - LW'(1)));
          lf_wdata = lf_rdata;
        end else begin
          lf_we = (wl_q < LW'(fin_cnt_q));
        end
      end
      ST_WNODE: begin
        nd_we = r_write;
        if (op_q == OP_INIT) begin
          lf_we    = 1'b1;
          lf_waddr = leaf_addr(n_q, '0);
          lf_wdata = id_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      ld_q        <= '0;
      wl_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      m_q         <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + NW'(1);
      step_q <= (state_q == ST_NRD) ? step_q + 3'd1 : '0;
      ld_q   <= (state_q == ST_LOAD) ? ld_q + LW'(1) : '0;
      wl_q   <= (state_q == ST_WLEAF) ? wl_q + LW'(1) : '0;
      if (state_q == ST_PREP) begin
        i_q <= '0; j_q <= '0; m_q <= '0; ovf_q <= 1'b0;
      end else if (state_q == ST_MERGE && m_more) begin
        if (m_q >= k_lim) begin
          ovf_q <= 1'b1;
        end else begin
          if (m_take_a) i_q <= i_q + CNT_W'(1);
          if (m_take_b) j_q <= j_q + CNT_W'(1);
          m_q <= m_q + CNT_W'(1);
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= opcode_i;
      id_q     <= node_id_i;
      fa_q     <= fanin_a_i;
      fb_q     <= fanin_b_i;
      n_q      <= node_of(node_id_i);
      n0_q     <= node_of(fanin_a_i);
      n1_q     <= node_of(fanin_b_i);
      ns_q     <= node_of(sibling_id_i);
      nsrc_q   <= node_of(source_id_i);
      sib_nz_q <= (sibling_id_i != '0);
      subp_q   <= subtract_period_i;
      dv_q     <= depth_value_i;
    end
    if (state_q == ST_NRD && step_q != '0) begin
      rd_q[step_q[1:0] - 2'd1] <= nd_rdata;
    end
    // pick the deeper fanin cut; the other fanin may count as one leaf
    if (state_q == ST_PREP) begin
      bcut_q <= (rd_q[0].depth == rd_q[1].depth);
      b_node_q <= n1_q;
      if ($signed(rd_q[0].depth) >= $signed(rd_q[1].depth)) begin
        a_node_q <= n0_q;
        ka_q     <= rd_q[0].cnt;
        lvl_q    <= (rd_q[0].depth == '0) ? DEPTH_W'(1) : rd_q[0].depth;
      end else begin
        a_node_q <= n1_q;
        ka_q     <= rd_q[1].cnt;
        lvl_q    <= (rd_q[1].depth == '0) ? DEPTH_W'(1) : rd_q[1].depth;
      end
      if (rd_q[0].depth == rd_q[1].depth) begin
        kb_q <= rd_q[1].cnt;
      end else begin
        kb_q      <= CNT_W'(1);
        bbuf_q[0] <= ($signed(rd_q[0].depth) > $signed(rd_q[1].depth)) ? fb_q : fa_q;
      end
    end
    // leaf loads land in the cycle after their read
    if (state_q == ST_LOAD && ld_q != '0) begin
      if ((ld_q - LW'(1)) < LW'(ka_q)) begin
        abuf_q[SW'(ld_q - LW'(1))] <= lf_rdata;
      end else begin
        bbuf_q[SW'(ld_q - LW'(1) - LW'(ka_q))] <= lf_rdata;
      end
    end
    if (state_q == ST_MERGE && m_more && (m_q < k_lim)) begin
      rbuf_q[m_q[SW-1:0]] <= m_val;
    end
    if (state_q == ST_RESOLVE) begin
      if (ovf_q) begin
        rbuf_q[0] <= f_lo;
        rbuf_q[1] <= f_hi;
      end
      use_sib_q <= c_sib;
      fin_cnt_q <= c_sib ? rd_q[2].cnt : c_cnt;
      fin_lvl_q <= c_sib ? rd_q[2].depth : c_lvl;
    end
    if (state_q == ST_DONE && out_free) begin
      out_depth_q <= r_depth;
      out_cnt_q   <= r_cnt;
      out_chg_q   <= r_chg;
      out_over_q  <= r_over;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign node_depth_o    = out_depth_q;
  assign cut_size_o      = out_cnt_q;
  assign depth_changed_o = out_chg_q;
  assign over_period_o   = out_over_q;

  // checks
  a_merge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (m_q <= k_lim))
    else $error("merge count past lut size");

  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (ld_q <= ld_total))
    else $error("leaf load past fanin cuts");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("accepted word not started");

  a_clear_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !out_valid_q)
    else $error("result during clearing pass");

endmodule

@@ rtl/core/lcde_ram.sv @@
// Simple dual-port RAM: one write port, one registered read port.
module lcde_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 36,
  parameter int unsigned AW    = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench of the LUT cut depth engine.
`timescale 1ns / 100ps

module testbench;
  import lcde_pkg::*;

  localparam int NODES  = 4096;
  localparam int LEAVES = 8;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [ID_W-1:0]           id;
    logic [ID_W-1:0]           fa;
    logic [ID_W-1:0]           fb;
    logic [ID_W-1:0]           sib;
    logic [ID_W-1:0]           src;
    logic                      sub;
    logic signed [DEPTH_W-1:0] dval;
  } node_word_t;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth;
    logic [CNT_W-1:0]          cnt;
    logic                      changed;
    logic                      over;
  } depth_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OP_W-1:0] opcode_i = '0;
  logic [ID_W-1:0] node_id_i = '0, fanin_a_i = '0, fanin_b_i = '0;
  logic [ID_W-1:0] sibling_id_i = '0, source_id_i = '0;
  logic subtract_period_i = 1'b0;
  logic signed [DEPTH_W-1:0] depth_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DEPTH_W-1:0] node_depth_o;
  logic [CNT_W-1:0] cut_size_o;
  logic depth_changed_o, over_period_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [PER_W-1:0] cfg_data_i = '0;

  // shadow of the node store and registers
  logic [LEAF_W-1:0]         leaf_mem [NODES*LEAVES];
  logic [CNT_W-1:0]          cnt_mem  [NODES];
  logic signed [DEPTH_W-1:0] depth_mem[NODES];
  logic [CNT_W-1:0]          k_reg;
  logic [PER_W-1:0]          period_reg;

  depth_word_t expected_depths[$];
  int     fail_cnt = 0;
  longint cycle_cnt = 0;
  bit     hold_off = 1'b0;
  bit     no_gaps = 1'b0;

  always #2 clk_i = ~clk_i;

  lut_cut_depth_engine i_dut (.*);

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL lut_cut_depth_engine");
      $finish;
    end
  end

  function automatic logic signed [DEPTH_W-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[DEPTH_W-1:0];
  endfunction

  // and-node mapping on the shadow store; returns the changed flag
  function automatic logic map_and_node(node_word_t w);
    int n, n0, n1, ns, k, na, nb, i, j, cnt, ks;
    logic [LEAF_W-1:0] ca[LEAVES], cb[LEAVES], res[LEAVES];
    logic [LEAF_W-1:0] v, lo, hi;
    logic signed [DEPTH_W-1:0] l0, l1, lvl, lvl_old, l2;
    bit ovf;
    n = int'(w.id); n0 = int'(w.fa); n1 = int'(w.fb);
    lvl_old = depth_mem[n];
    l0 = depth_mem[n0]; l1 = depth_mem[n1];
    lvl = (l0 > l1) ? l0 : l1;
    k = (int'(k_reg) < 2) ? 2 : ((int'(k_reg) > LEAVES) ? LEAVES : int'(k_reg));
    for (i = 0; i < LEAVES; i++) res[i] = '0;
    if (lvl == 0) lvl = 1;
    if (l0 == l1) begin
      for (i = 0; i < LEAVES; i++) begin
        ca[i] = leaf_mem[n0*LEAVES+i]; cb[i] = leaf_mem[n1*LEAVES+i];
      end
      na = int'(cnt_mem[n0]); nb = int'(cnt_mem[n1]);
    end else if (l0 > l1) begin
      for (i = 0; i < LEAVES; i++) ca[i] = leaf_mem[n0*LEAVES+i];
      cb[0] = w.fb; na = int'(cnt_mem[n0]); nb = 1;
    end else begin
      for (i = 0; i < LEAVES; i++) ca[i] = leaf_mem[n1*LEAVES+i];
      cb[0] = w.fa; na = int'(cnt_mem[n1]); nb = 1;
    end
    // sorted union, bailing out past K leaves
    i = 0; j = 0; cnt = 0; ovf = 1'b0;
    while (!ovf && (i < na || j < nb)) begin
      if (cnt >= k) ovf = 1'b1;
      else begin
        if (i < na && j < nb) begin
          if (ca[i] == cb[j]) begin v = ca[i]; i++; j++; end
          else if (ca[i] < cb[j]) begin v = ca[i]; i++; end
          else begin v = cb[j]; j++; end
        end else if (i < na) begin v = ca[i]; i++; end
        else begin v = cb[j]; j++; end
        res[cnt] = v; cnt++;
      end
    end
    if (ovf) begin
      lo = (w.fa < w.fb) ? w.fa : w.fb;
      hi = (w.fa < w.fb) ? w.fb : w.fa;
      res[0] = lo; cnt = 1;
      if (hi != lo) begin res[1] = hi; cnt = 2; end
      lvl = clamp32(longint'(lvl) + 1);
    end
    if (w.sib != 0) begin
      ns = int'(w.sib); l2 = depth_mem[ns]; ks = int'(cnt_mem[ns]);
      if (!(lvl < l2 || (lvl == l2 && cnt <= ks))) begin
        for (i = 0; i < LEAVES; i++) res[i] = leaf_mem[ns*LEAVES+i];
        cnt = ks; lvl = l2;
      end
    end
    for (i = 0; i < LEAVES; i++) leaf_mem[n*LEAVES+i] = res[i];
    cnt_mem[n] = CNT_W'(cnt);
    if (lvl > lvl_old) depth_mem[n] = lvl;
    return lvl > lvl_old;
  endfunction

  function automatic depth_word_t predict_depth(node_word_t w);
    depth_word_t r;
    longint d;
    r = '0;
    case (w.op)
      OP_INIT: begin
        leaf_mem[w.id*LEAVES] = w.id; cnt_mem[w.id] = 1; depth_mem[w.id] = 0;
      end
      OP_AND:   r.changed = map_and_node(w);
      OP_QUERY: r.over = longint'(depth_mem[w.id]) > longint'(period_reg);
      OP_COPY: begin
        d = longint'(depth_mem[w.src]);
        if (w.sub) d = d - longint'(period_reg);
        depth_mem[w.id] = clamp32(d);
      end
      OP_SET: depth_mem[w.id] = w.dval;
      default: ;
    endcase
    r.depth = depth_mem[w.id];
    r.cnt = cnt_mem[w.id];
    return r;
  endfunction

  // send one word, predicting at acceptance
  task automatic send_word(node_word_t w);
    opcode_i <= w.op; node_id_i <= w.id; fanin_a_i <= w.fa; fanin_b_i <= w.fb;
    sibling_id_i <= w.sib; source_id_i <= w.src; subtract_period_i <= w.sub;
    depth_value_i <= w.dval; in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_depths.push_back(predict_depth(w));
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    int t;
    t = 0;
    while (expected_depths.size() != 0 && t < 100000) begin
      @(posedge clk_i); t++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  // one register write; valid drops between writes
  task automatic write_cfg(logic idx, logic [PER_W-1:0] val);
    cfg_index_i <= idx; cfg_data_i <= val; cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_LUT_SIZE) k_reg = val[CNT_W-1:0];
    else period_reg = val;
    @(posedge clk_i);
  endtask

  function automatic node_word_t mk_word(logic [OP_W-1:0] op, int id, int fa = 0,
                                          int fb = 0, int sib = 0);
    node_word_t w;
    w = '0;
    w.op = op; w.id = ID_W'(id); w.fa = ID_W'(fa); w.fb = ID_W'(fb); w.sib = ID_W'(sib);
    return w;
  endfunction

  // ids drawn mostly from a small pool so cuts and fanins interact
  function automatic int pick_id(int pool);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, NODES-1);
    return $urandom_range(1, pool);
  endfunction

  function automatic node_word_t rand_word(int pool);
    node_word_t w;
    int r;
    w.op = OP_AND; w.id = ID_W'(pick_id(pool));
    w.fa = ID_W'(pick_id(pool)); w.fb = ID_W'(pick_id(pool));
    w.sib = ($urandom_range(0, 2) == 0) ? ID_W'(pick_id(pool)) : '0;
    w.src = ID_W'(pick_id(pool)); w.sub = 1'($urandom_range(0, 1));
    w.dval = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 20);
    r = $urandom_range(0, 99);
    if (r < 15) w.op = OP_INIT;
    else if (r < 65) w.op = OP_AND;
    else if (r < 77) w.op = OP_QUERY;
    else if (r < 87) w.op = OP_COPY;
    else if (r < 96) w.op = OP_SET;
    else w.op = OP_W'($urandom_range(5, 7));
    return w;
  endfunction

  // receiver stall pattern plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= (cycle_cnt[6] == 1'b1) ? ($urandom_range(0, 2) == 0) : 1'b0;
  end

  // result checker
  always @(posedge clk_i) begin
    depth_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_depths.size() == 0) begin
        $display("%0t: unexpected result depth %0d", $time, node_depth_o);
        fail_cnt++;
      end else begin
        e = expected_depths.pop_front();
        if (node_depth_o !== e.depth) begin
          $display("%0t: node_depth exp %0d got %0d", $time, e.depth, node_depth_o);
          fail_cnt++;
        end
        if (cut_size_o !== e.cnt) begin
          $display("%0t: cut_size exp %0d got %0d", $time, e.cnt, cut_size_o);
          fail_cnt++;
        end
        if (depth_changed_o !== e.changed) begin
          $display("%0t: depth_changed exp %0b got %0b", $time, e.changed,
                   depth_changed_o);
          fail_cnt++;
        end
        if (over_period_o !== e.over) begin
          $display("%0t: over_period exp %0b got %0b", $time, e.over, over_period_o);
          fail_cnt++;
        end
      end
    end
  end

  // directed: extremes, every opcode, aliasing, sibling
  task automatic test_directed();
    node_word_t w;
    send_word(mk_word(OP_QUERY, 0));
    send_word(mk_word(OP_INIT, 1));
    send_word(mk_word(OP_INIT, 2));
    send_word(mk_word(OP_INIT, 4095));
    send_word(mk_word(OP_AND, 10, 1, 2));
    send_word(mk_word(OP_AND, 11, 10, 4095));
    send_word(mk_word(OP_AND, 11, 11, 11));
    send_word(mk_word(OP_AND, 12, 1, 4095, 10));
    send_word(mk_word(OP_AND, 13, 10, 11, 4095));
    w = mk_word(OP_SET, 20); w.dval = 32'sh7fffffff; send_word(w);
    send_word(mk_word(OP_AND, 21, 20, 20));
    w = mk_word(OP_SET, 22); w.dval = 32'sh80000000; send_word(w);
    w = mk_word(OP_COPY, 23); w.src = 22; w.sub = 1'b1; send_word(w);
    send_word(mk_word(OP_QUERY, 23));
    send_word(mk_word(OP_QUERY, 20));
    w = mk_word(OP_COPY, 24); w.src = 20; w.sub = 1'b0; send_word(w);
    send_word(mk_word(5, 24));
    send_word(mk_word(6, 10));
    send_word(mk_word(7, 4095));
    w = mk_word(OP_SET, 1); w.dval = -5; send_word(w);
    send_word(mk_word(OP_AND, 25, 1, 2, 4095));
    drop_valid();
  endtask

  // build long cuts so small K overflows
  task automatic test_overflow();
    int i;
    for (i = 100; i < 110; i++) send_word(mk_word(OP_INIT, i));
    send_word(mk_word(OP_AND, 110, 100, 101));
    send_word(mk_word(OP_AND, 111, 102, 103));
    send_word(mk_word(OP_AND, 112, 110, 111));
    send_word(mk_word(OP_AND, 113, 104, 105));
    send_word(mk_word(OP_AND, 114, 112, 113));
    send_word(mk_word(OP_AND, 115, 114, 114, 112));
    send_word(mk_word(OP_QUERY, 114));
    drop_valid();
  endtask

  task automatic test_random(int count, int pool);
    int i;
    for (i = 0; i < count; i++) send_word(rand_word(pool));
    drop_valid();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        no_gaps = 1'b1;
        test_random(30, 40);
        no_gaps = 1'b0;
      end
    join
  endtask

  initial begin
    foreach (leaf_mem[i]) leaf_mem[i] = '0;
    foreach (cnt_mem[i]) cnt_mem[i] = '0;
    foreach (depth_mem[i]) depth_mem[i] = '0;
    k_reg = LUT_SIZE_RST;
    period_reg = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    drain();
    write_cfg(CFG_LUT_SIZE, 2);
    write_cfg(CFG_PERIOD, 4095);
    test_overflow();
    drain();
    write_cfg(CFG_LUT_SIZE, 8);
    write_cfg(CFG_PERIOD, 3);
    test_overflow();
    test_random(200, 30);
    drain();
    write_cfg(CFG_LUT_SIZE, 15);
    write_cfg(CFG_PERIOD, 0);
    test_random(150, 60);
    test_backpressure();
    drain();
    write_cfg(CFG_LUT_SIZE, 0);
    write_cfg(CFG_PERIOD, 1);
    test_random(150, 20);
    drain();
    write_cfg(CFG_LUT_SIZE, 4);
    write_cfg(CFG_PERIOD, PER_W'($urandom_range(0, 4095)));
    test_random(150, 50);
    drain();

    if (fail_cnt == 0 && expected_depths.size() == 0) begin
      $display("PASS lut_cut_depth_engine");
    end else begin
      $display("FAIL lut_cut_depth_engine");
    end
    $finish;
  end

endmodule
